/* hdl/lrupr_pkg.sv */
// Shared types and constants for the LRU page replacement block.
// No dependencies; used by lrupr_ctrl, lrupr_dpath and lru_page_replacement.
`default_nettype none

package lrupr_pkg;

  localparam int unsigned PAGE_W  = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned OIDX_W  = 4;
  localparam int unsigned CFG_W   = 5;

  localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic start;   // latch reference, advance use clock, restart scan
    logic scan;    // step the frame scan by one frame
    logic commit;  // update the chosen frame and load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;  // all active frames compared, no read in flight
  } sts_t;

endpackage

`default_nettype wire

/* hdl/lrupr_ctrl.sv */
// Controller state machine for the LRU page replacement block.
// Depends on lrupr_pkg; drives lrupr_dpath through cmd_t, reads sts_t.
`default_nettype none

module lrupr_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire lrupr_pkg::sts_t sts_i,
  output lrupr_pkg::cmd_t    cmd_o
);
  import lrupr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold the update until the result register can take it
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* hdl/lrupr_dpath.sv */
// Datapath for the LRU page replacement block: frame memories, scan, stamps.
// Depends on lrupr_pkg; controlled by lrupr_ctrl through cmd_t and sts_t.
`default_nettype none

module lrupr_dpath #(
  parameter int unsigned FRAMES = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire lrupr_pkg::cmd_t                 cmd_i,
  output lrupr_pkg::sts_t                      sts_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [lrupr_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic [lrupr_pkg::PAGE_W-1:0]    page_i,
  output logic                                 res_hit_o,
  output logic [lrupr_pkg::OIDX_W-1:0]         res_idx_o,
  output logic [lrupr_pkg::COUNT_W-1:0]        res_faults_o
);
  import lrupr_pkg::*;

  localparam int unsigned FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W  = $clog2(FRAMES + 1);
  localparam logic [CNT_W-1:0] N_MAX = CNT_W'(FRAMES);

  // frame memories: one read and one write port each
  logic [PAGE_W-1:0]  page_mem  [FRAMES];
  logic [STAMP_W-1:0] stamp_mem [FRAMES];
  logic [FRAMES-1:0]  valid_q;

  logic [CFG_W-1:0]   cfg_q;
  logic [CNT_W-1:0]   n_active;

  logic [PAGE_W-1:0]  page_q;
  logic [STAMP_W-1:0] clock_q;
  logic [COUNT_W-1:0] faults_q;

  logic [CNT_W-1:0]   addr_q;
  logic               rd_vld_q;
  logic [FIDX_W-1:0]  rd_idx_q;
  logic [PAGE_W-1:0]  rd_page_q;
  logic [STAMP_W-1:0] rd_stamp_q;

  logic               hit_q, empty_q, old_set_q;
  logic [FIDX_W-1:0]  hit_idx_q, empty_idx_q, old_idx_q;
  logic [STAMP_W-1:0] old_stamp_q;

  logic               rd_valid_bit;
  logic               scan_more;
  logic [FIDX_W-1:0]  chosen;

  always_comb begin
    if (cfg_q == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(cfg_q) > 32'(FRAMES)) begin
      n_active = N_MAX;
    end else begin
      n_active = CNT_W'(cfg_q);
    end
  end

  assign scan_more    = addr_q != n_active;
  assign rd_valid_bit = valid_q[rd_idx_q];
  assign sts_o.scan_done = !scan_more && !rd_vld_q;

  always_comb begin
    if (hit_q) begin
      chosen = hit_idx_q;
    end else if (empty_q) begin
      chosen = empty_idx_q;
    end else begin
      chosen = old_idx_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q    <= CFG_RESET;
      valid_q  <= '0;
      clock_q  <= '0;
      faults_q <= '0;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      if (cmd_i.start) begin
        addr_q   <= '0;
        rd_vld_q <= 1'b0;
        if (clock_q != STAMP_MAX) begin
          clock_q <= clock_q + STAMP_W'(1);
        end
      end else if (cmd_i.scan) begin
        rd_vld_q <= scan_more;
        if (scan_more) begin
          addr_q <= addr_q + CNT_W'(1);
        end
      end
      if (cmd_i.commit && !hit_q) begin
        valid_q[chosen] <= 1'b1;
        if (faults_q != COUNT_MAX) begin
          faults_q <= faults_q + COUNT_W'(1);
        end
      end
    end
  end

  // memory reads, one frame per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && scan_more) begin
      rd_page_q  <= page_mem[addr_q[FIDX_W-1:0]];
      rd_stamp_q <= stamp_mem[addr_q[FIDX_W-1:0]];
      rd_idx_q   <= addr_q[FIDX_W-1:0];
    end
  end

  // memory writes at commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      stamp_mem[chosen] <= clock_q;
      if (!hit_q) begin
        page_mem[chosen] <= page_q;
      end
    end
  end

  // running search results; first match, first empty, oldest stamp (strict <)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= 1'b0;
      empty_q   <= 1'b0;
      old_set_q <= 1'b0;
    end else if (cmd_i.start) begin
      hit_q     <= 1'b0;
      empty_q   <= 1'b0;
      old_set_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (rd_valid_bit && rd_page_q == page_q && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (!rd_valid_bit && !empty_q) begin
        empty_q <= 1'b1;
      end
      if (rd_valid_bit) begin
        old_set_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      page_q <= page_i;
    end
    if (rd_vld_q) begin
      if (rd_valid_bit && rd_page_q == page_q && !hit_q) begin
        hit_idx_q <= rd_idx_q;
      end
      if (!rd_valid_bit && !empty_q) begin
        empty_idx_q <= rd_idx_q;
      end
      if (rd_valid_bit && (!old_set_q || rd_stamp_q < old_stamp_q)) begin
        old_idx_q   <= rd_idx_q;
        old_stamp_q <= rd_stamp_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_hit_o    <= hit_q;
      res_idx_o    <= OIDX_W'(chosen);
      res_faults_o <= (!hit_q && faults_q != COUNT_MAX) ? faults_q + COUNT_W'(1)
                                                        : faults_q;
    end
  end

endmodule

`default_nettype wire

/* hdl/lru_page_replacement.sv */
// Channel   Dir  Signals                         Payload
// s_axis    in   tvalid/tready/tdata[15:0]       page_number
// m_axis    out  tvalid/tready/tuser, tdata[39:0] hit; frame_index, fault_total
// cfg       in   cfg_wr_en_i/cfg_wr_data_i[4:0]  frames_in_use
//
// After accept, a reference scans the n active frames, n being the active
// frame count: the frame memories have one read port and are scanned one
// frame per cycle, then a commit step updates the chosen frame.
// A new reference is accepted while the previous result still waits on m_axis;
// its update waits until the result register is free.
// Reset clears valid marks, use clock and fault count; no clearing pass.
// Depends on lrupr_pkg, lrupr_ctrl, lrupr_dpath.
`default_nettype none

module lru_page_replacement #(
  parameter int unsigned FRAMES = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wr_en_i,
  input  wire logic [4:0]  cfg_wr_data_i,   // frames_in_use
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,    // [15:0] page_number
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,    // [3:0] frame_index, [35:4] fault_total, rest 0
  output logic             m_axis_tuser     // hit
);
  import lrupr_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic               res_hit;
  logic [OIDX_W-1:0]  res_idx;
  logic [COUNT_W-1:0] res_faults;

  lrupr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lrupr_dpath #(
    .FRAMES (FRAMES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_wr_en_i),
    .cfg_data_i   (cfg_wr_data_i),
    .page_i       (s_axis_tdata),
    .res_hit_o    (res_hit),
    .res_idx_o    (res_idx),
    .res_faults_o (res_faults)
  );

  assign m_axis_tuser = res_hit;
  assign m_axis_tdata = {4'b0000, res_faults, res_idx};

`ifndef ASSERT_OFF
  // an accepted reference keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after an accepted reference");

  // commit only after the scan has drained
  a_commit_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> sts.scan_done)
    else $error("frame update before scan finished");

  // every commit presents a result
  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid)
    else $error("commit without result");

  // a commit never overwrites a result that was not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten");
`endif

endmodule

`default_nettype wire
